FILE: hdl/s8fp_pkg.sv
// ----------------------------------------------------------------------------
// SUM8 frame parser package
// Shared types, status codes, register indexes and reset values.
// ----------------------------------------------------------------------------
package s8fp_pkg;

  localparam int BYTE_W   = 8;
  localparam int STATUS_W = 3;
  localparam int ERR_W    = 16;
  localparam int CFG_IDX_W = 2;
  localparam int TDATA_W  = 56;

  localparam logic [STATUS_W-1:0] STATUS_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] STATUS_DROPPED  = 3'd1;
  localparam logic [STATUS_W-1:0] STATUS_BAD_SUM  = 3'd2;
  localparam logic [STATUS_W-1:0] STATUS_BAD_TAIL = 3'd3;
  localparam logic [STATUS_W-1:0] STATUS_TOO_LONG = 3'd4;
  localparam logic [STATUS_W-1:0] STATUS_BAD_CMD  = 3'd5;

  localparam logic [CFG_IDX_W-1:0] CFG_HEADER_BYTE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TAIL_BYTE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LENGTH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CMD_ENABLE  = 2'd3;

  localparam logic [BYTE_W-1:0] HEADER_RESET     = 8'h55;
  localparam logic [BYTE_W-1:0] TAIL_RESET       = 8'hAA;
  localparam logic [BYTE_W-1:0] MAX_LENGTH_RESET = 8'd64;
  localparam logic [BYTE_W-1:0] CMD_ENABLE_RESET = 8'hFF;

  localparam logic [BYTE_W-1:0] CMD_LIMIT   = 8'd128;
  localparam logic [BYTE_W-1:0] CMD_HANDLED = 8'd8;
  localparam logic [ERR_W-1:0]  ERR_MAX     = 16'hFFFF;

  typedef struct packed {
    logic                we;
    logic [CFG_IDX_W-1:0] index;
    logic [BYTE_W-1:0]    data;
  } cfg_write_t;

  typedef struct packed {
    logic                payload_valid;
    logic [BYTE_W-1:0]   payload_byte;
    logic [BYTE_W-1:0]   payload_index;
    logic                frame_done;
    logic [STATUS_W-1:0] frame_status;
    logic [BYTE_W-1:0]   frame_command;
    logic [BYTE_W-1:0]   frame_length;
    logic [ERR_W-1:0]    error_total;
  } result_t;

endpackage

FILE: hdl/s8fp_parser.sv
// ----------------------------------------------------------------------------
// SUM8 frame parser state machine
// Holds the configuration registers and the frame state, and works out the
// result of each accepted byte in one pass.
// ----------------------------------------------------------------------------
module s8fp_parser (
  input  logic                       clk,
  input  logic                       rst,
  input  s8fp_pkg::cfg_write_t       cfg,
  input  logic                       accept,
  input  logic [s8fp_pkg::BYTE_W-1:0] rx_byte,
  output s8fp_pkg::result_t          result
);

  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_CMD    = 3'd1,
    PH_LEN    = 3'd2,
    PH_DATA   = 3'd3,
    PH_SUM    = 3'd4,
    PH_TAIL   = 3'd5
  } phase_t;

  logic [s8fp_pkg::BYTE_W-1:0] header_byte;
  logic [s8fp_pkg::BYTE_W-1:0] tail_byte;
  logic [s8fp_pkg::BYTE_W-1:0] max_length;
  logic [s8fp_pkg::BYTE_W-1:0] command_enable_mask;

  phase_t                      phase, phase_next;
  logic [s8fp_pkg::BYTE_W-1:0] command_code, command_code_next;
  logic [s8fp_pkg::BYTE_W-1:0] payload_length, payload_length_next;
  logic [s8fp_pkg::BYTE_W-1:0] bytes_received, bytes_received_next;
  logic [s8fp_pkg::BYTE_W-1:0] running_sum, running_sum_next;
  logic [s8fp_pkg::BYTE_W-1:0] received_checksum, received_checksum_next;
  logic [s8fp_pkg::ERR_W-1:0]  error_counter, error_counter_next;
  logic [s8fp_pkg::BYTE_W-1:0] count_inc;
  logic                        restart;
  logic                        bump;
  logic                        cmd_enabled;

  assign count_inc   = bytes_received + 8'd1;
  assign cmd_enabled = (command_code < s8fp_pkg::CMD_HANDLED) &&
                       command_enable_mask[command_code[2:0]];

  always_comb begin
    result                 = '0;
    phase_next             = phase;
    command_code_next      = command_code;
    payload_length_next    = payload_length;
    bytes_received_next    = bytes_received;
    running_sum_next       = running_sum;
    received_checksum_next = received_checksum;
    restart                = 1'b0;
    bump                   = 1'b0;
    case (phase)
      PH_HEADER: begin
        if (rx_byte == header_byte) begin
          phase_next = PH_CMD;
        end
      end
      PH_CMD: begin
        command_code_next = rx_byte;
        phase_next        = PH_LEN;
      end
      PH_LEN: begin
        if (rx_byte > max_length) begin
          result.frame_done    = 1'b1;
          result.frame_status  = s8fp_pkg::STATUS_TOO_LONG;
          result.frame_command = command_code;
          result.frame_length  = rx_byte;
          bump                 = 1'b1;
          restart              = 1'b1;
        end else begin
          payload_length_next = rx_byte;
          bytes_received_next = '0;
          running_sum_next    = command_code + rx_byte;
          phase_next          = (rx_byte == '0) ? PH_SUM : PH_DATA;
        end
      end
      PH_DATA: begin
        result.payload_valid = 1'b1;
        result.payload_byte  = rx_byte;
        result.payload_index = bytes_received;
        running_sum_next     = running_sum + rx_byte;
        bytes_received_next  = count_inc;
        if (count_inc >= payload_length) begin
          phase_next = PH_SUM;
        end
      end
      PH_SUM: begin
        received_checksum_next = rx_byte;
        phase_next             = PH_TAIL;
      end
      PH_TAIL: begin
        result.frame_done    = 1'b1;
        result.frame_command = command_code;
        result.frame_length  = payload_length;
        if (rx_byte != tail_byte) begin
          result.frame_status = s8fp_pkg::STATUS_BAD_TAIL;
          bump                = 1'b1;
        end else if (running_sum != received_checksum) begin
          result.frame_status = s8fp_pkg::STATUS_BAD_SUM;
          bump                = 1'b1;
        end else if (command_code > s8fp_pkg::CMD_LIMIT) begin
          result.frame_status = s8fp_pkg::STATUS_BAD_CMD;
          bump                = 1'b1;
        end else if (cmd_enabled) begin
          result.frame_status = s8fp_pkg::STATUS_OK;
        end else begin
          result.frame_status = s8fp_pkg::STATUS_DROPPED;
        end
        restart = 1'b1;
      end
      default: begin
        restart = 1'b1;
      end
    endcase
    if (restart) begin
      phase_next             = PH_HEADER;
      command_code_next      = '0;
      payload_length_next    = '0;
      bytes_received_next    = '0;
      running_sum_next       = '0;
      received_checksum_next = '0;
    end
    error_counter_next = error_counter;
    if (bump && (error_counter != s8fp_pkg::ERR_MAX)) begin
      error_counter_next = error_counter + 16'd1;
    end
    result.error_total = error_counter_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_byte         <= s8fp_pkg::HEADER_RESET;
      tail_byte           <= s8fp_pkg::TAIL_RESET;
      max_length          <= s8fp_pkg::MAX_LENGTH_RESET;
      command_enable_mask <= s8fp_pkg::CMD_ENABLE_RESET;
    end else if (cfg.we) begin
      case (cfg.index)
        s8fp_pkg::CFG_HEADER_BYTE: header_byte         <= cfg.data;
        s8fp_pkg::CFG_TAIL_BYTE:   tail_byte           <= cfg.data;
        s8fp_pkg::CFG_MAX_LENGTH:  max_length          <= cfg.data;
        s8fp_pkg::CFG_CMD_ENABLE:  command_enable_mask <= cfg.data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_HEADER;
      command_code      <= '0;
      payload_length    <= '0;
      bytes_received    <= '0;
      running_sum       <= '0;
      received_checksum <= '0;
      error_counter     <= '0;
    end else if (accept) begin
      phase             <= phase_next;
      command_code      <= command_code_next;
      payload_length    <= payload_length_next;
      bytes_received    <= bytes_received_next;
      running_sum       <= running_sum_next;
      received_checksum <= received_checksum_next;
      error_counter     <= error_counter_next;
    end
  end

endmodule

FILE: hdl/s8fp_out_buffer.sv
// ----------------------------------------------------------------------------
// SUM8 frame parser output buffer
// Output register with a skid stage, so input ready is a registered signal.
// ----------------------------------------------------------------------------
module s8fp_out_buffer (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  s8fp_pkg::result_t  in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output s8fp_pkg::result_t  out_item
);

  logic              skid_valid;
  s8fp_pkg::result_t skid_item;
  logic              in_take;

  assign in_ready = !skid_valid;
  assign in_take  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        out_item   <= skid_item;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= in_take;
        out_item  <= in_item;
      end
    end else if (in_take) begin
      skid_valid <= 1'b1;
      skid_item  <= in_item;
    end
  end

endmodule

FILE: hdl/sum8_frame_parser_core.sv
// ----------------------------------------------------------------------------
// SUM8 frame parser core
// Parses header, command, length, payload, SUM8, tail frames one byte per item.
// ----------------------------------------------------------------------------
// A result item goes to the output register, or to the skid stage and then the
// output register when stalled; one byte per cycle while the skid stage is empty.
// A two-entry output buffer keeps the input side running while results wait.
// Reset is synchronous: registers return to their defaults, the parser waits
// for a header, the error counter clears and both buffers empty.
module sum8_frame_parser_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // rx_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // payload_byte, payload_index, frame_status, frame_command, frame_length,
  // error_total, zero fill
  output logic [s8fp_pkg::TDATA_W-1:0] m_axis_tdata,
  output logic        m_axis_tlast,   // frame_done
  output logic        m_axis_tuser,   // payload_valid
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  s8fp_pkg::cfg_write_t cfg;
  s8fp_pkg::result_t    result;
  s8fp_pkg::result_t    out_item;
  logic                 accept;

  assign cfg.we    = cfg_we;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;
  assign accept    = s_axis_tvalid && s_axis_tready;

  s8fp_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .accept  (accept),
    .rx_byte (s_axis_tdata),
    .result  (result)
  );

  s8fp_out_buffer u_out_buffer (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_item   (result),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_item  (out_item)
  );

  assign m_axis_tdata = {5'd0, out_item.error_total, out_item.frame_length,
                         out_item.frame_command, out_item.frame_status,
                         out_item.payload_index, out_item.payload_byte};
  assign m_axis_tlast = out_item.frame_done;
  assign m_axis_tuser = out_item.payload_valid;

endmodule

FILE: hdl/s8fp_checker.sv
// ----------------------------------------------------------------------------
// SUM8 frame parser port checker
// Watches the top-level ports and flags output items that break the format.
// ----------------------------------------------------------------------------
module s8fp_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [55:0] m_axis_tdata,
  input logic        m_axis_tlast,
  input logic        m_axis_tuser
);

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("Output item changed while stalled.");

  a_ready_after_reset: assert property (@(posedge clk)
    rst |=> s_axis_tready)
    else $error("Input not ready after reset.");

  a_payload_not_done: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !(m_axis_tuser && m_axis_tlast))
    else $error("Item marked both payload and frame end.");

  a_quiet_fields: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[34:16] == '0)
    else $error("Frame fields set on an item that ends no frame.");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[18:16] <= s8fp_pkg::STATUS_BAD_CMD)
    else $error("Frame status out of range.");

endmodule

bind sum8_frame_parser_core s8fp_checker u_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);

FILE: test/sum8_frame_parser_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// SUM8 frame parser core testbench
// Sends received bytes as single items and checks every result item against
// a cycle-free model of the parser. Covers directed frames, register changes
// while a frame is open, output back-pressure and randomized frames under
// several register settings.
// ----------------------------------------------------------------------------
module sum8_frame_parser_core_tb;

  typedef enum logic [2:0] {
    WAIT_HEADER, GET_COMMAND, GET_LENGTH, GET_PAYLOAD, GET_SUM, GET_TAIL
  } parse_phase_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'd0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        m_axis_tuser;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = s8fp_pkg::CFG_HEADER_BYTE;
  logic [7:0]  cfg_data = 8'd0;

  logic [7:0] hdr_cfg = s8fp_pkg::HEADER_RESET;
  logic [7:0] tail_cfg = s8fp_pkg::TAIL_RESET;
  logic [7:0] max_len_cfg = s8fp_pkg::MAX_LENGTH_RESET;
  logic [7:0] enable_cfg = s8fp_pkg::CMD_ENABLE_RESET;

  parse_phase_t phase_m = WAIT_HEADER;
  logic [7:0]   cmd_m = 8'd0;
  logic [7:0]   len_m = 8'd0;
  logic [7:0]   got_m = 8'd0;
  logic [7:0]   sum_m = 8'd0;
  logic [7:0]   rx_sum_m = 8'd0;
  logic [15:0]  err_m = 16'd0;

  s8fp_pkg::result_t pending_parser_outputs[$];
  int      bytes_sent = 0;
  int      bad_outputs = 0;
  int      hold_cycles = 0;
  int      out_stall = 0;
  bit      idle_on = 1'b1;

  sum8_frame_parser_core u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic void restart_frame_model();
    phase_m = WAIT_HEADER;
    cmd_m = 8'd0;
    len_m = 8'd0;
    got_m = 8'd0;
    sum_m = 8'd0;
    rx_sum_m = 8'd0;
  endfunction

  function automatic void count_frame_error();
    if (err_m != s8fp_pkg::ERR_MAX) err_m = err_m + 16'd1;
  endfunction

  function automatic s8fp_pkg::result_t parse_rx_byte(input logic [7:0] b);
    s8fp_pkg::result_t r;
    r = '0;
    case (phase_m)
      WAIT_HEADER: begin
        if (b == hdr_cfg) phase_m = GET_COMMAND;
      end
      GET_COMMAND: begin
        cmd_m = b;
        phase_m = GET_LENGTH;
      end
      GET_LENGTH: begin
        if (b > max_len_cfg) begin
          r.frame_done = 1'b1;
          r.frame_status = s8fp_pkg::STATUS_TOO_LONG;
          r.frame_command = cmd_m;
          r.frame_length = b;
          count_frame_error();
          restart_frame_model();
        end else begin
          len_m = b;
          got_m = 8'd0;
          sum_m = cmd_m + b;
          phase_m = (b == 8'd0) ? GET_SUM : GET_PAYLOAD;
        end
      end
      GET_PAYLOAD: begin
        r.payload_valid = 1'b1;
        r.payload_byte = b;
        r.payload_index = got_m;
        sum_m = sum_m + b;
        got_m = got_m + 8'd1;
        if (got_m >= len_m) phase_m = GET_SUM;
      end
      GET_SUM: begin
        rx_sum_m = b;
        phase_m = GET_TAIL;
      end
      GET_TAIL: begin
        r.frame_done = 1'b1;
        r.frame_command = cmd_m;
        r.frame_length = len_m;
        if (b != tail_cfg) begin
          r.frame_status = s8fp_pkg::STATUS_BAD_TAIL;
          count_frame_error();
        end else if (sum_m != rx_sum_m) begin
          r.frame_status = s8fp_pkg::STATUS_BAD_SUM;
          count_frame_error();
        end else if (cmd_m > s8fp_pkg::CMD_LIMIT) begin
          r.frame_status = s8fp_pkg::STATUS_BAD_CMD;
          count_frame_error();
        end else if (cmd_m < s8fp_pkg::CMD_HANDLED && enable_cfg[cmd_m[2:0]]) begin
          r.frame_status = s8fp_pkg::STATUS_OK;
        end else begin
          r.frame_status = s8fp_pkg::STATUS_DROPPED;
        end
        restart_frame_model();
      end
      default: begin
        restart_frame_model();
      end
    endcase
    r.error_total = err_m;
    return r;
  endfunction

  function automatic string describe_output(input s8fp_pkg::result_t r);
    return {$sformatf("valid=%0d byte=%02h index=%0d done=%0d ",
                      r.payload_valid, r.payload_byte, r.payload_index, r.frame_done),
            $sformatf("status=%0d cmd=%02h len=%0d errors=%0d",
                      r.frame_status, r.frame_command, r.frame_length, r.error_total)};
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = idle_on ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    do @(posedge clk); while (!s_axis_tready);
    pending_parser_outputs.push_back(parse_rx_byte(b));
    bytes_sent++;
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (pending_parser_outputs.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic put_reg(input logic [1:0] idx, input logic [7:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  task automatic set_regs(input logic [7:0] hv, input logic [7:0] tv,
                          input logic [7:0] mv, input logic [7:0] ev);
    put_reg(s8fp_pkg::CFG_HEADER_BYTE, hv);
    put_reg(s8fp_pkg::CFG_TAIL_BYTE, tv);
    put_reg(s8fp_pkg::CFG_MAX_LENGTH, mv);
    put_reg(s8fp_pkg::CFG_CMD_ENABLE, ev);
    cfg_we <= 1'b0;
    hdr_cfg = hv;
    tail_cfg = tv;
    max_len_cfg = mv;
    enable_cfg = ev;
  endtask

  // Assumes the parser is waiting for a header. The frame ends at the length
  // byte when the length is over the current limit.
  task automatic send_frame(input logic [7:0] cmd, input logic [7:0] len,
                            input logic [7:0] sum_flip, input logic [7:0] tail_val,
                            input int hdr_pct);
    logic [7:0] sum;
    logic [7:0] b;
    sum = cmd + len;
    send_byte(hdr_cfg);
    send_byte(cmd);
    send_byte(len);
    if (len <= max_len_cfg) begin
      for (int i = 0; i < len; i++) begin
        b = ($urandom_range(0, 99) < hdr_pct) ? hdr_cfg : 8'($urandom);
        sum = sum + b;
        send_byte(b);
      end
      send_byte(sum ^ sum_flip);
      send_byte(tail_val);
    end
  endtask

  task automatic test_directed_frames();
    send_byte(8'h00);
    send_frame(8'h00, 8'd0, 8'h00, tail_cfg, 0);
    send_frame(s8fp_pkg::CMD_LIMIT, 8'd1, 8'h00, tail_cfg, 100);
    send_frame(8'hFF, 8'hFF, 8'h00, tail_cfg, 0);
    send_frame(s8fp_pkg::CMD_LIMIT + 8'd1, 8'd0, 8'h01, ~tail_cfg, 0);
    send_frame(8'd200, 8'd0, 8'h80, tail_cfg, 0);
    send_frame(s8fp_pkg::CMD_LIMIT + 8'd1, 8'd0, 8'h00, tail_cfg, 0);
    drain_results();
  endtask

  task automatic test_reg_write_mid_frame();
    send_byte(hdr_cfg);
    send_byte(8'd3);
    send_byte(8'd2);
    send_byte(8'h11);
    drain_results();
    set_regs(s8fp_pkg::HEADER_RESET, 8'h0F, 8'd1, 8'hF7);
    send_byte(8'h22);
    send_byte(8'd3 + 8'd2 + 8'h11 + 8'h22);
    send_byte(8'h0F);
    send_byte(hdr_cfg);
    send_byte(8'd1);
    drain_results();
    set_regs(s8fp_pkg::HEADER_RESET, s8fp_pkg::TAIL_RESET, 8'd0,
             s8fp_pkg::CMD_ENABLE_RESET);
    send_byte(8'd1);
    drain_results();
    set_regs(s8fp_pkg::HEADER_RESET, s8fp_pkg::TAIL_RESET, s8fp_pkg::MAX_LENGTH_RESET,
             s8fp_pkg::CMD_ENABLE_RESET);
  endtask

  task automatic test_backpressure();
    hold_cycles = 80;
    repeat (4) begin
      send_frame(8'($urandom_range(0, 7)), 8'($urandom_range(1, 4)), 8'h00, tail_cfg, 10);
    end
    drain_results();
  endtask

  task automatic test_random_frames();
    logic [7:0] hv, tv, mv, ev;
    logic [7:0] cmd, len, flip, tl;
    int start;
    int pick;
    for (int s = 0; s < 6; s++) begin
      case (s)
        0: begin
          hv = s8fp_pkg::HEADER_RESET;
          tv = s8fp_pkg::TAIL_RESET;
          mv = s8fp_pkg::MAX_LENGTH_RESET;
          ev = s8fp_pkg::CMD_ENABLE_RESET;
        end
        1: begin
          hv = 8'h00; tv = 8'hFF; mv = 8'h00; ev = 8'h00;
        end
        2: begin
          hv = 8'hFF; tv = 8'h00; mv = 8'hFF; ev = 8'hFF;
        end
        default: begin
          hv = 8'($urandom); tv = 8'($urandom);
          mv = 8'($urandom_range(0, 20)); ev = 8'($urandom);
        end
      endcase
      set_regs(hv, tv, mv, ev);
      start = bytes_sent;
      while (bytes_sent - start < 60) begin
        idle_on = ($urandom_range(0, 3) != 0);
        if ($urandom_range(0, 9) == 0) begin
          repeat ($urandom_range(1, 5)) begin
            send_byte(($urandom_range(0, 3) == 0) ? hdr_cfg : 8'($urandom));
          end
          while (phase_m != WAIT_HEADER) begin
            send_byte((phase_m == GET_LENGTH) ? 8'd0 : 8'($urandom));
          end
        end else begin
          pick = $urandom_range(0, 99);
          if (pick < 60) cmd = 8'($urandom_range(0, 7));
          else if (pick < 75) cmd = 8'($urandom_range(8, 128));
          else if (pick < 90) cmd = 8'($urandom_range(129, 255));
          else cmd = hdr_cfg;
          pick = $urandom_range(0, 99);
          if (pick < 80 || max_len_cfg == 8'hFF) len = 8'($urandom_range(0, 6));
          else if (pick < 90) len = 8'($urandom_range(int'(max_len_cfg) + 1, 255));
          else if (max_len_cfg <= 8'd20) len = max_len_cfg;
          else len = 8'($urandom_range(7, 16));
          flip = ($urandom_range(0, 9) < 8) ? 8'h00 : 8'($urandom_range(1, 255));
          tl = ($urandom_range(0, 9) < 8) ? tail_cfg : tail_cfg ^ 8'($urandom_range(1, 255));
          send_frame(cmd, len, flip, tl, 10);
        end
      end
      drain_results();
    end
    idle_on = 1'b1;
  endtask

  always @(posedge clk) begin : output_check
    s8fp_pkg::result_t seen;
    s8fp_pkg::result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      seen.payload_valid = m_axis_tuser;
      seen.payload_byte = m_axis_tdata[7:0];
      seen.payload_index = m_axis_tdata[15:8];
      seen.frame_done = m_axis_tlast;
      seen.frame_status = m_axis_tdata[18:16];
      seen.frame_command = m_axis_tdata[26:19];
      seen.frame_length = m_axis_tdata[34:27];
      seen.error_total = m_axis_tdata[50:35];
      if (pending_parser_outputs.size() == 0) begin
        bad_outputs++;
        if (bad_outputs <= 10) $display("unexpected item: %s", describe_output(seen));
      end else begin
        want = pending_parser_outputs.pop_front();
        if (seen !== want) begin
          bad_outputs++;
          if (bad_outputs <= 10) begin
            $display("mismatch at %0t", $realtime);
            $display("  expected %s", describe_output(want));
            $display("  actual   %s", describe_output(seen));
          end
        end
      end
      out_stall = idle_on ? $urandom_range(0, 6) : 0;
    end
    if (hold_cycles > 0) begin
      hold_cycles--;
      m_axis_tready <= 1'b0;
    end else if (out_stall > 0) begin
      out_stall--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  initial begin
    #10_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_directed_frames();
    test_reg_write_mid_frame();
    test_backpressure();
    test_random_frames();
    drain_results();
    repeat (5) @(posedge clk);
    if (bad_outputs == 0 && pending_parser_outputs.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
